/* sv/calendar_clock_with_dst_defines.svh */
// Assertion macros of the calendar clock RTL
`ifndef CALENDAR_CLOCK_WITH_DST_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_DST_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define RTCC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define RTCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/rtcc_pkg.sv */
// Shared types, constants and defaults of the calendar clock
package rtcc_pkg;

   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int WDAY_W  = 3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [YEAR_W-1:0]  DEF_YEAR   = 14'd2024;
   localparam logic [MONTH_W-1:0] DEF_MONTH  = 4'd1;
   localparam logic [DAY_W-1:0]   DEF_DAY    = 5'd1;
   localparam logic [WDAY_W-1:0]  DEF_WDAY   = 3'd0;
   localparam logic [HOUR_W-1:0]  DEF_HOUR   = 5'd0;
   localparam logic [MIN_W-1:0]   DEF_MINUTE = 6'd0;

   typedef enum logic [2:0] {
      REG_YEAR    = 3'd0,
      REG_MONTH   = 3'd1,
      REG_DAY     = 3'd2,
      REG_WEEKDAY = 3'd3,
      REG_HOUR    = 3'd4,
      REG_MINUTE  = 3'd5
   } rtcc_reg_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [WDAY_W-1:0]  wday;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   sec;
      logic               fallback;
   } rtcc_time_type;

   // Time-set strobe from the register block to the counters
   typedef struct packed {
      logic                  we;
      rtcc_reg_type          idx;
      logic [CSR_DATA_W-1:0] data;
   } rtcc_load_type;

endpackage

/* sv/rtcc_intf.sv */
// Request and result channel interfaces of the calendar clock
interface rtcc_req_intf;
   import rtcc_pkg::*;
   logic valid;
   logic ready;
   logic seconds_elapsed;

   modport source (output valid, output seconds_elapsed, input ready);
   modport sink (input valid, input seconds_elapsed, output ready);
endinterface

interface rtcc_rsp_intf;
   import rtcc_pkg::*;
   logic               valid;
   logic               ready;
   logic [SEC_W-1:0]   second_now;
   logic [MIN_W-1:0]   minute_now;
   logic [HOUR_W-1:0]  hour_now;
   logic [DAY_W-1:0]   day_now;
   logic [MONTH_W-1:0] month_now;
   logic [YEAR_W-1:0]  year_now;
   logic [WDAY_W-1:0]  weekday_now;
   logic               autumn_shift_done;

   modport source (output valid, output second_now, output minute_now, output hour_now,
                   output day_now, output month_now, output year_now,
                   output weekday_now, output autumn_shift_done, input ready);
   modport sink (input valid, input second_now, input minute_now, input hour_now,
                 input day_now, input month_now, input year_now,
                 input weekday_now, input autumn_shift_done, output ready);
endinterface

/* sv/calendar_clock_with_dst.sv */
// Calendar clock with daylight saving: one request per cycle while the result
// channel is not stalled; a request passes the request register, then the result register.
// The time counters advance in a single pass of rtcc_step, whose carry chain
// and leap-year multiply are combinational. The counters load the defaults
// at reset and the written value whenever a start register is written over APB.
`include "calendar_clock_with_dst_defines.svh"
module calendar_clock_with_dst (
   input  logic                            clock,
   input  logic                            reset,
   rtcc_req_intf.sink                      req_chan,
   rtcc_rsp_intf.source                    rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rtcc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rtcc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rtcc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rtcc_pkg::*;

   rtcc_load_type load;
   rtcc_time_type cur_ff, cur_in;
   rtcc_time_type rsp_ff, rsp_in;
   rtcc_time_type next_time;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_tick_ff, s1_tick_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_take;
   logic          step_adv;
   logic          rsp_matches;

   rtcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .load        (load)
   );

   rtcc_step u_step (
      .cur  (cur_ff),
      .tick (s1_tick_ff),
      .nxt  (next_time)
   );

   assign step_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || step_adv;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (step_adv ? 1'b0 : s1_valid_ff);
      s1_tick_in   = req_take ? req_chan.seconds_elapsed : s1_tick_ff;
      rsp_valid_in = step_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = step_adv ? next_time : rsp_ff;

      cur_in = step_adv ? next_time : cur_ff;
      // time set: a start-register write also loads its counter
      if (load.we) begin
         case (load.idx)
            REG_YEAR:    cur_in.year   = load.data[YEAR_W-1:0];
            REG_MONTH:   cur_in.month  = load.data[MONTH_W-1:0];
            REG_DAY:     cur_in.day    = load.data[DAY_W-1:0];
            REG_WEEKDAY: cur_in.wday   = load.data[WDAY_W-1:0];
            REG_HOUR:    cur_in.hour   = load.data[HOUR_W-1:0];
            REG_MINUTE:  cur_in.minute = load.data[MIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cur_ff.year     <= DEF_YEAR;
         cur_ff.month    <= DEF_MONTH;
         cur_ff.day      <= DEF_DAY;
         cur_ff.wday     <= DEF_WDAY;
         cur_ff.hour     <= DEF_HOUR;
         cur_ff.minute   <= DEF_MINUTE;
         cur_ff.sec      <= '0;
         cur_ff.fallback <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tick_ff <= s1_tick_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.second_now        = rsp_ff.sec;
   assign rsp_chan.minute_now        = rsp_ff.minute;
   assign rsp_chan.hour_now          = rsp_ff.hour;
   assign rsp_chan.day_now           = rsp_ff.day;
   assign rsp_chan.month_now         = rsp_ff.month;
   assign rsp_chan.year_now          = rsp_ff.year;
   assign rsp_chan.weekday_now       = rsp_ff.wday;
   assign rsp_chan.autumn_shift_done = rsp_ff.fallback;

   assign rsp_matches = (rsp_ff == cur_ff);

   // a freshly stepped result is the new clock state
   `RTCC_ASSERT_NEXT(a_rsp_is_state, step_adv, rsp_matches, "result differs from clock state")
   // seconds never leave 0..59 after a step
   `RTCC_ASSERT_NEXT(a_sec_range, step_adv, cur_ff.sec < 6'd60, "seconds out of range")
   // a held request blocks new ones
   `RTCC_ASSERT_SAME(a_hold_blocks, s1_valid_ff && !step_adv, !req_chan.ready, "request overrun")
   // the fallback flag only changes on a step
   `RTCC_ASSERT_NEXT(a_flag_steady, !step_adv, cur_ff.fallback == $past(cur_ff.fallback), "flag moved without a step")

endmodule

/* sv/rtcc_csr.sv */
// APB register block holding the start-time registers
module rtcc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rtcc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rtcc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rtcc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output rtcc_pkg::rtcc_load_type         load
);
   import rtcc_pkg::*;

   logic [YEAR_W-1:0]  year_ff,   year_in;
   logic [MONTH_W-1:0] month_ff,  month_in;
   logic [DAY_W-1:0]   day_ff,    day_in;
   logic [WDAY_W-1:0]  wday_ff,   wday_in;
   logic [HOUR_W-1:0]  hour_ff,   hour_in;
   logic [MIN_W-1:0]   minute_ff, minute_in;

   rtcc_reg_type idx;
   logic         wr;

   assign idx        = rtcc_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   assign load.we   = wr;
   assign load.idx  = idx;
   assign load.data = csr_pwdata;

   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      wday_in   = wday_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      if (wr) begin
         case (idx)
            REG_YEAR:    year_in   = csr_pwdata[YEAR_W-1:0];
            REG_MONTH:   month_in  = csr_pwdata[MONTH_W-1:0];
            REG_DAY:     day_in    = csr_pwdata[DAY_W-1:0];
            REG_WEEKDAY: wday_in   = csr_pwdata[WDAY_W-1:0];
            REG_HOUR:    hour_in   = csr_pwdata[HOUR_W-1:0];
            REG_MINUTE:  minute_in = csr_pwdata[MIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= DEF_YEAR;
         month_ff  <= DEF_MONTH;
         day_ff    <= DEF_DAY;
         wday_ff   <= DEF_WDAY;
         hour_ff   <= DEF_HOUR;
         minute_ff <= DEF_MINUTE;
      end else begin
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         wday_ff   <= wday_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
      end
   end

   always_comb begin
      case (idx)
         REG_YEAR:    csr_prdata = CSR_DATA_W'(year_ff);
         REG_MONTH:   csr_prdata = CSR_DATA_W'(month_ff);
         REG_DAY:     csr_prdata = CSR_DATA_W'(day_ff);
         REG_WEEKDAY: csr_prdata = CSR_DATA_W'(wday_ff);
         REG_HOUR:    csr_prdata = CSR_DATA_W'(hour_ff);
         REG_MINUTE:  csr_prdata = CSR_DATA_W'(minute_ff);
         default:     csr_prdata = '0;
      endcase
   end

endmodule

/* sv/rtcc_step.sv */
// One-step time advance: carry ripple, daylight saving and calendar rollover
module rtcc_step (
   input  rtcc_pkg::rtcc_time_type cur,
   input  logic                    tick,
   output rtcc_pkg::rtcc_time_type nxt
);
   import rtcc_pkg::*;

   // ceil(2^19 / 100); low product bits below it mean the year divides by 100
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_100   = (1 << RECIP_SHIFT) / 100 + 1;
   localparam int PROD_W      = YEAR_W + 13;

   logic [SEC_W:0]        s;
   logic [MIN_W:0]        mi;
   logic [HOUR_W:0]       h;
   logic [DAY_W:0]        d;
   logic [WDAY_W:0]       wp1;
   logic [WDAY_W-1:0]     w;
   logic [MONTH_W-1:0]    mo;
   logic [YEAR_W-1:0]     y;
   logic                  flag;
   logic                  late_sunday;
   logic [PROD_W-1:0]     yprod;
   logic                  div100;
   logic                  leap;
   logic [DAY_W-1:0]      len;

   assign yprod  = PROD_W'(cur.year) * PROD_W'(RECIP_100);
   assign div100 = yprod[RECIP_SHIFT-1:0] < RECIP_SHIFT'(RECIP_100);
   // with div100, the quotient's low two bits give the 400-year rule
   assign leap   = div100 ? (yprod[RECIP_SHIFT+1:RECIP_SHIFT] == 2'd0)
                          : (cur.year[1:0] == 2'd0);

   always_comb begin
      case (cur.month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
   end

   always_comb begin
      s    = {1'b0, cur.sec} + (SEC_W+1)'(tick);
      mi   = {1'b0, cur.minute};
      h    = {1'b0, cur.hour};
      d    = {1'b0, cur.day};
      w    = cur.wday;
      mo   = cur.month;
      y    = cur.year;
      flag = cur.fallback;

      if (s >= 7'd60) begin
         mi = mi + 7'd1;
         s  = '0;
      end
      if (mi >= 7'd60) begin
         h  = h + 6'd1;
         mi = '0;
      end
      wp1 = {1'b0, w} + 4'd1;
      if (h >= 6'd24) begin
         d = d + 6'd1;
         h = '0;
         w = (wp1 >= 4'd7) ? WDAY_W'(wp1 - 4'd7) : wp1[WDAY_W-1:0];
      end

      late_sunday = (w == 3'd6) && (d >= 6'd25);
      if (mo == 4'd3 && h == 6'd2 && late_sunday) begin
         flag = 1'b0;
         h    = 6'd3;
      end
      if (mo == 4'd10 && h == 6'd3 && late_sunday && !flag) begin
         flag = 1'b1;
         h    = 6'd2;
      end

      if (len != 5'd0 && d > {1'b0, len}) begin
         mo = mo + 4'd1;
         d  = 6'd1;
      end
      if (mo > 4'd12) begin
         y  = (y >= 14'd9999) ? '0 : y + 14'd1;
         mo = 4'd1;
      end

      nxt.sec      = s[SEC_W-1:0];
      nxt.minute   = mi[MIN_W-1:0];
      nxt.hour     = h[HOUR_W-1:0];
      nxt.day      = d[DAY_W-1:0];
      nxt.wday     = w;
      nxt.month    = mo;
      nxt.year     = y;
      nxt.fallback = flag;
   end

endmodule

/* bench/calendar_clock_with_dst_tb.sv */
// Self-checking testbench of the calendar clock: predicted time per request, APB time set
module calendar_clock_with_dst_tb;
   import rtcc_pkg::*;

   localparam int NUM_REGS        = 6;
   localparam int SECS_PER_MIN    = 60;
   localparam int MINS_PER_HOUR   = 60;
   localparam int HOURS_PER_DAY   = 24;
   localparam int DAYS_PER_WEEK   = 7;
   localparam int SUNDAY          = 6;
   localparam int FEBRUARY        = 2;
   localparam int MARCH           = 3;
   localparam int OCTOBER         = 10;
   localparam int DECEMBER        = 12;
   localparam int SPRING_HOUR     = 2;
   localparam int AUTUMN_HOUR     = 3;
   localparam int LAST_YEAR       = 9999;
   localparam int RANDOM_ITEMS    = 1330;
   localparam int STALL_ITEMS     = 120;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_GAP         = 6;
   localparam int MAX_BURST       = 40;
   localparam int MAX_PRINTED     = 100;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rtcc_req_intf req_if ();
   rtcc_rsp_intf rsp_if ();

   calendar_clock_with_dst uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rtcc_time_type cal_state;
   rtcc_time_type pending_times [$];
   logic [31:0]   start_regs [NUM_REGS];
   int            error_count  = 0;
   int            result_count = 0;
   int            burst_left   = 0;
   bit            hold_off_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // generous ceiling on the whole run
   initial begin
      #(20 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int month_days(input int mo, input int yr);
      case (mo)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         FEBRUARY: begin
            if ((yr % 400) == 0 || ((yr % 4) == 0 && (yr % 100) != 0)) return 29;
            return 28;
         end
         default:               return 0;
      endcase
   endfunction

   function automatic rtcc_time_type tick_calendar(input rtcc_time_type t, input logic secs);
      int unsigned   s, mi, h, d, mo, y, w, len;
      rtcc_time_type n;
      n  = t;
      s  = 32'(t.sec) + 32'(secs);
      mi = 32'(t.minute);
      h  = 32'(t.hour);
      d  = 32'(t.day);
      mo = 32'(t.month);
      y  = 32'(t.year);
      w  = 32'(t.wday);
      if (s >= SECS_PER_MIN) begin
         mi++;
         s = 0;
      end
      if (mi >= MINS_PER_HOUR) begin
         h++;
         mi = 0;
      end
      if (h >= HOURS_PER_DAY) begin
         d++;
         h = 0;
         w = (w + 1) % DAYS_PER_WEEK;
      end
      // last Sunday of the month: day 25 or later
      if (mo == MARCH && h == SPRING_HOUR && w == SUNDAY && d + 7 > 31) begin
         n.fallback = 1'b0;
         h++;
      end
      if (mo == OCTOBER && h == AUTUMN_HOUR && w == SUNDAY && d + 7 > 31 && !n.fallback) begin
         n.fallback = 1'b1;
         h--;
      end
      len = month_days(mo, y);
      if (len != 0 && d > len) begin
         mo++;
         d = 1;
      end
      if (mo > DECEMBER) begin
         y  = (y >= LAST_YEAR) ? 0 : y + 1;
         mo = 1;
      end
      n.sec    = SEC_W'(s);
      n.minute = MIN_W'(mi);
      n.hour   = HOUR_W'(h);
      n.day    = DAY_W'(d);
      n.month  = MONTH_W'(mo);
      n.year   = YEAR_W'(y);
      n.wday   = WDAY_W'(w);
      return n;
   endfunction

   function automatic int reg_width(input rtcc_reg_type idx);
      case (idx)
         REG_YEAR:    return YEAR_W;
         REG_MONTH:   return MONTH_W;
         REG_DAY:     return DAY_W;
         REG_WEEKDAY: return WDAY_W;
         REG_HOUR:    return HOUR_W;
         default:     return MIN_W;
      endcase
   endfunction

   function automatic logic [31:0] pick_start_value(input rtcc_reg_type idx);
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, (1 << reg_width(idx)) - 1);
      case (idx)
         REG_YEAR:    return $urandom_range(0, LAST_YEAR);
         REG_MONTH:   return $urandom_range(1, DECEMBER);
         REG_DAY:     return $urandom_range(1, 31);
         REG_WEEKDAY: return $urandom_range(0, SUNDAY);
         REG_HOUR:    return $urandom_range(0, HOURS_PER_DAY - 1);
         default:     return $urandom_range(0, MINS_PER_HOUR - 1);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                   result_count, name, got, want));
   endtask

   task automatic check_result();
      rtcc_time_type want;
      if (pending_times.size() == 0) begin
         report_mismatch("result with no request pending");
         return;
      end
      want = pending_times.pop_front();
      check_field("second",   int'(rsp_if.second_now),        int'(want.sec));
      check_field("minute",   int'(rsp_if.minute_now),        int'(want.minute));
      check_field("hour",     int'(rsp_if.hour_now),          int'(want.hour));
      check_field("day",      int'(rsp_if.day_now),           int'(want.day));
      check_field("month",    int'(rsp_if.month_now),         int'(want.month));
      check_field("year",     int'(rsp_if.year_now),          int'(want.year));
      check_field("weekday",  int'(rsp_if.weekday_now),       int'(want.wday));
      check_field("fallback", int'(rsp_if.autumn_shift_done), int'(want.fallback));
      result_count++;
   endtask

   always @(posedge clock)
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_result();

   // receiver: stretches of differing stall patterns, plus a long hold-off on demand
   initial begin : rsp_ready_pattern
      int mode;
      int span;
      int k;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            for (k = 0; k < HOLD_OFF_CYCLES; k++) begin
               rsp_if.ready <= 1'b0;
               @(posedge clock);
            end
            hold_off_req = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (k = 0; k < span && !hold_off_req; k++) begin
               case (mode)
                  0:       rsp_if.ready <= 1'b1;
                  1:       rsp_if.ready <= ($urandom_range(0, 9) < 7);
                  2:       rsp_if.ready <= ($urandom_range(0, 9) < 3);
                  default: rsp_if.ready <= ((k % 5) < 2);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_request(input logic secs);
      req_if.valid           <= 1'b1;
      req_if.seconds_elapsed <= secs;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      cal_state = tick_calendar(cal_state, secs);
      pending_times.push_back(cal_state);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         burst_left = $urandom_range(0, MAX_BURST);
      end
   endtask

   task automatic idle_request_channel();
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_times.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input rtcc_reg_type idx, input logic [31:0] value);
      logic [31:0] masked;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // the write also loads the matching counter
      masked = value & ((32'd1 << reg_width(idx)) - 32'd1);
      start_regs[int'(idx)] = masked;
      case (idx)
         REG_YEAR:    cal_state.year   = YEAR_W'(masked);
         REG_MONTH:   cal_state.month  = MONTH_W'(masked);
         REG_DAY:     cal_state.day    = DAY_W'(masked);
         REG_WEEKDAY: cal_state.wday   = WDAY_W'(masked);
         REG_HOUR:    cal_state.hour   = HOUR_W'(masked);
         default:     cal_state.minute = MIN_W'(masked);
      endcase
   endtask

   task automatic csr_read(input rtcc_reg_type idx, output logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_start_regs();
      logic [31:0] got;
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_read(rtcc_reg_type'(i), got);
         if (got !== start_regs[i])
            report_mismatch($sformatf("register %0d read %0d expected %0d",
                                      i, got, start_regs[i]));
      end
   endtask

   task automatic load_time(input int yr, input int mo, input int d, input int w,
                            input int h, input int mi);
      csr_write(REG_YEAR, yr);
      csr_write(REG_MONTH, mo);
      csr_write(REG_DAY, d);
      csr_write(REG_WEEKDAY, w);
      csr_write(REG_HOUR, h);
      csr_write(REG_MINUTE, mi);
   endtask

   task automatic set_time_and_tick(input int yr, input int mo, input int d, input int w,
                                    input int h, input int mi);
      load_time(yr, mo, d, w, h, mi);
      send_request(1'($urandom_range(0, 1)));
      idle_request_channel();
      wait_drained();
   endtask

   task automatic test_reset_defaults();
      check_start_regs();
      send_request(1'b0);
      send_request(1'b1);
      idle_request_channel();
      wait_drained();
   endtask

   task automatic test_field_extremes();
      set_time_and_tick(2024, 1, 1, 0, 0, 63);        // minute out of range carries
      set_time_and_tick(2024, 1, 1, 0, 31, 0);        // hour out of range carries a day
      set_time_and_tick(2024, 1, 1, 7, 24, 0);        // weekday seven wraps to one
      set_time_and_tick(2024, 0, 31, 3, 24, 0);       // month zero: day wraps to zero
      set_time_and_tick(2024, 15, 5, 2, 10, 10);      // month above twelve
      set_time_and_tick(LAST_YEAR, 13, 1, 0, 0, 0);   // year rollover
      set_time_and_tick(16383, 13, 1, 0, 0, 0);
      set_time_and_tick(0, DECEMBER, 31, 6, 24, 59);  // new year from year zero
      set_time_and_tick(2024, 1, 0, 0, 5, 0);         // day zero stays
      set_time_and_tick(2024, 4, 31, 1, 5, 0);        // day past month end
   endtask

   task automatic test_leap_years();
      set_time_and_tick(2000, FEBRUARY, 29, 1, 24, 0);
      set_time_and_tick(1900, FEBRUARY, 28, 1, 24, 0);
      set_time_and_tick(2024, FEBRUARY, 28, 1, 24, 0);
      set_time_and_tick(2023, FEBRUARY, 28, 1, 24, 0);
      set_time_and_tick(2024, 6, 30, 4, 24, 0);
      set_time_and_tick(2024, 8, 31, 4, 24, 0);
   endtask

   task automatic test_daylight_saving();
      set_time_and_tick(2024, MARCH, 25, SUNDAY, SPRING_HOUR, 0);
      set_time_and_tick(2024, MARCH, 24, SUNDAY, SPRING_HOUR, 0);   // not the last Sunday
      set_time_and_tick(2024, OCTOBER, 31, SUNDAY, AUTUMN_HOUR, 0);
      send_request(1'b1);                                           // stays back one hour
      idle_request_channel();
      wait_drained();
      set_time_and_tick(2024, OCTOBER, 27, SUNDAY, AUTUMN_HOUR, 30);  // flag already set
      set_time_and_tick(2024, MARCH, 31, SUNDAY, SPRING_HOUR, 59);  // clears the flag
   endtask

   task automatic setup_random_phase(output int ones_pct);
      int scen;
      int yr;
      int mo;
      scen     = $urandom_range(0, 6);
      ones_pct = $urandom_range(90, 100);
      case (scen)
         0: begin
            for (int i = 0; i < NUM_REGS; i++)
               if ($urandom_range(0, 1)) csr_write(rtcc_reg_type'(i),
                                                   pick_start_value(rtcc_reg_type'(i)));
            ones_pct = $urandom_range(30, 100);
         end
         1: begin
            csr_write(REG_WEEKDAY, $urandom_range(0, 7));
            csr_write(REG_HOUR, HOURS_PER_DAY - 1);
            csr_write(REG_MINUTE, MINS_PER_HOUR - 1);
         end
         2: begin
            yr = int'(cal_state.year);
            mo = $urandom_range(1, DECEMBER);
            csr_write(REG_MONTH, mo);
            csr_write(REG_DAY, month_days(mo, yr));
            csr_write(REG_HOUR, HOURS_PER_DAY - 1);
            csr_write(REG_MINUTE, MINS_PER_HOUR - 1);
         end
         3: begin
            csr_write(REG_YEAR, ($urandom_range(0, 2) == 0) ? LAST_YEAR
                                                             : $urandom_range(0, LAST_YEAR));
            csr_write(REG_MONTH, DECEMBER);
            csr_write(REG_DAY, 31);
            csr_write(REG_HOUR, HOURS_PER_DAY - 1);
            csr_write(REG_MINUTE, MINS_PER_HOUR - 1);
         end
         4: begin
            // spring forward reached by an hour carry, sometimes loaded directly
            csr_write(REG_MONTH, MARCH);
            csr_write(REG_DAY, $urandom_range(23, 31));
            csr_write(REG_WEEKDAY, ($urandom_range(0, 4) == 0) ? 5 : SUNDAY);
            csr_write(REG_HOUR, ($urandom_range(0, 3) == 0) ? SPRING_HOUR : SPRING_HOUR - 1);
            csr_write(REG_MINUTE, MINS_PER_HOUR - 1);
         end
         5: begin
            csr_write(REG_MONTH, OCTOBER);
            csr_write(REG_DAY, $urandom_range(23, 31));
            csr_write(REG_WEEKDAY, ($urandom_range(0, 4) == 0) ? 5 : SUNDAY);
            csr_write(REG_HOUR, ($urandom_range(0, 3) == 0) ? AUTUMN_HOUR : AUTUMN_HOUR - 1);
            csr_write(REG_MINUTE, MINS_PER_HOUR - 1);
         end
         default: begin
            case ($urandom_range(0, 6))
               0:       yr = 2000;
               1:       yr = 1900;
               2:       yr = 2024;
               3:       yr = 2023;
               4:       yr = 2100;
               5:       yr = 2400;
               default: yr = $urandom_range(0, LAST_YEAR);
            endcase
            csr_write(REG_YEAR, yr);
            csr_write(REG_MONTH, FEBRUARY);
            csr_write(REG_DAY, $urandom_range(28, 29));
            csr_write(REG_HOUR, HOURS_PER_DAY - 1);
            csr_write(REG_MINUTE, MINS_PER_HOUR - 1);
         end
      endcase
   endtask

   task automatic test_random_calendar();
      int sent;
      int count;
      int ones_pct;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         setup_random_phase(ones_pct);
         check_start_regs();
         count = $urandom_range(30, 90);
         repeat (count) send_request($urandom_range(0, 99) < ones_pct);
         sent += count;
         idle_request_channel();
         wait_drained();
      end
   endtask

   task automatic test_result_backpressure();
      load_time(2024, DECEMBER, 31, SUNDAY, HOURS_PER_DAY - 1, MINS_PER_HOUR - 1);
      hold_off_req = 1'b1;
      repeat (STALL_ITEMS) send_request($urandom_range(0, 9) != 0);
      idle_request_channel();
      wait_drained();
   endtask

   initial begin
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.seconds_elapsed <= 1'b0;
      csr_psel               <= 1'b0;
      csr_penable            <= 1'b0;
      csr_pwrite             <= 1'b0;
      csr_paddr              <= '0;
      csr_pwdata             <= '0;
      start_regs[int'(REG_YEAR)]    = 32'(DEF_YEAR);
      start_regs[int'(REG_MONTH)]   = 32'(DEF_MONTH);
      start_regs[int'(REG_DAY)]     = 32'(DEF_DAY);
      start_regs[int'(REG_WEEKDAY)] = 32'(DEF_WDAY);
      start_regs[int'(REG_HOUR)]    = 32'(DEF_HOUR);
      start_regs[int'(REG_MINUTE)]  = 32'(DEF_MINUTE);
      cal_state = '{year: DEF_YEAR, month: DEF_MONTH, day: DEF_DAY, wday: DEF_WDAY,
                    hour: DEF_HOUR, minute: DEF_MINUTE, sec: '0, fallback: 1'b0};
      burst_left = $urandom_range(0, MAX_BURST);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_leap_years();
      test_daylight_saving();
      test_random_calendar();
      test_result_backpressure();

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
